// ----- hw/rtl/wildcard_byte_pattern_scanner_core_assert.svh -----
// Assertion macros used by the wildcard byte pattern scanner report stage.
// Each macro expects clk and arst_n in the enclosing module.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define WBPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/wbps_pkg.sv -----
// Package for the wildcard byte pattern scanner: constants, register codes
// and the structs passed between the cell row, the report stage and the top.
package wbps_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int PAT_BYTES       = 16;      // configured pattern bytes
	localparam int PAT_IDX_W       = 4;
	localparam int LEN_W           = 7;       // holds lengths up to 127
	localparam int ADDR_W          = 64;
	localparam int CNT_W           = 14;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int IN_TDATA_W      = 8;
	localparam int OUT_TDATA_W     = 80;

	localparam logic [CNT_W-1:0] DEFAULT_LIMIT = CNT_W'(10000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO  = 3'd0,
		REG_PAT_HI  = 3'd1,
		REG_WILD    = 3'd2,
		REG_LEN     = 3'd3,
		REG_BASE    = 3'd4,
		REG_LIMIT   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] pat;
		logic [PAT_BYTES-1:0]      wild;
		logic [LEN_W-1:0]          len;
	} cell_cfg_t;

	typedef struct packed {
		logic              hit;
		logic              last;
		logic [ADDR_W-1:0] start;
	} s1_item_t;

endpackage

// ----- hw/rtl/wbps_cell.sv -----
// One window position of the scanner: holds a history byte, passes it on,
// and checks its compare byte against the aligned pattern byte. Uses wbps_pkg.
module wbps_cell #(
	parameter int POS = 0
) (
	input  logic                   clk,
	input  logic                   step,
	input  logic [7:0]             byte_in,
	input  wbps_pkg::cell_cfg_t    cfg,
	output logic [7:0]             byte_out,
	output logic                   hit
);
	import wbps_pkg::*;

	logic [7:0]       byte_q;
	logic [LEN_W-1:0] kk;
	logic             active;
	logic             in_pat;
	logic             eq;

	always_ff @(posedge clk) begin
		if (step) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

	// pattern byte kk lines up with this position
	assign kk     = cfg.len - LEN_W'(POS) - LEN_W'(1);
	assign active = LEN_W'(POS) < cfg.len;
	assign in_pat = kk < LEN_W'(PAT_BYTES);
	assign eq     = byte_in == cfg.pat[kk[PAT_IDX_W-1:0]];

	always_comb begin
		if (!active) begin
			hit = 1'b1;
		end else if (in_pat) begin
			hit = cfg.wild[kk[PAT_IDX_W-1:0]] | eq;
		end else begin
			hit = byte_in == 8'h00;
		end
	end

endmodule

// ----- hw/rtl/wbps_report.sv -----
// Report stage: applies the per-region result limit, counts matches, forms the
// match address and holds the output register. Uses wbps_pkg and the assert macros.
`include "wildcard_byte_pattern_scanner_core_assert.svh"

module wbps_report (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  wbps_pkg::s1_item_t                item,
	output logic                              take,
	input  logic [wbps_pkg::ADDR_W-1:0]       region_base,
	input  logic [wbps_pkg::CNT_W-1:0]        result_limit,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wbps_pkg::ADDR_W-1:0]       match_address,
	output logic [wbps_pkg::CNT_W-1:0]        match_index
);
	import wbps_pkg::*;

	logic              emit;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_v_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  idx_q;

	assign emit = item.hit & (cnt_q < result_limit);
	assign take = in_valid & (!emit | !out_v_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				if (item.last) begin
					cnt_q <= '0;
				end else if (emit) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (take & emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take & emit) begin
			addr_q <= region_base + item.start;
			idx_q  <= cnt_q;
		end
	end

	assign out_valid     = out_v_q;
	assign match_address = addr_q;
	assign match_index   = idx_q;

	`WBPS_ASSERT_NOW(a_emit_below_limit, take && emit, cnt_q < result_limit, "match past limit")
	`WBPS_ASSERT_NEXT(a_last_clears_count, take && item.last, cnt_q == '0, "count not cleared")
	`WBPS_ASSERT_NEXT(a_count_steps, take && emit && !item.last, cnt_q == $past(cnt_q) + CNT_W'(1), "count did not advance")
	`WBPS_ASSERT_NOW(a_no_overwrite, take && emit && out_v_q, out_ready, "pending result overwritten")

endmodule

// ----- hw/rtl/wildcard_byte_pattern_scanner_core.sv -----
// Top level of the wildcard byte pattern scanner: config registers, the row of
// window cells, the match stage register and the report stage. Uses wbps_pkg.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[7:0] data_byte, tlast region_last
//  m_axis    out  m_axis_tvalid/tready       tdata[63:0] address, [77:64] index
//  cfg       in   cfg_we                     cfg_index, cfg_data
//
// One byte per cycle unless input is blocked; results pass the match and output registers.
// The cell row compares the whole window against the pattern in the transfer cycle.
// Reset clears offset, fill, count and valid flags; config returns to reset values.
// A stalled result only blocks input when a further match is waiting behind it.
module wildcard_byte_pattern_scanner_core #(
	parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [wbps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [7:0] data_byte
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [wbps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [63:0] match_address, [77:64] match_index
	input  logic                                cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wbps_pkg::*;

	localparam int FILL_W = $clog2(PATTERN_MAX + 1);

	logic [63:0]       pat_lo_q;
	logic [63:0]       pat_hi_q;
	logic [15:0]       wild_q;
	logic [4:0]        plen_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  limit_q;

	logic [ADDR_W-1:0] off_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;
	logic [LEN_W-1:0]  len_eff;
	cell_cfg_t         cell_cfg;
	logic              accept;
	logic              all_hit;
	logic              hit;

	logic [7:0]             chain [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hits;

	logic     v_s1_q;
	s1_item_t item_s1;
	logic     s1_take;

	logic [ADDR_W-1:0] match_address;
	logic [CNT_W-1:0]  match_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q   <= '0;
			plen_q   <= '0;
			base_q   <= '0;
			limit_q  <= DEFAULT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PAT_LO: pat_lo_q <= cfg_data;
				REG_PAT_HI: pat_hi_q <= cfg_data;
				REG_WILD:   wild_q   <= cfg_data[15:0];
				REG_LEN:    plen_q   <= cfg_data[4:0];
				REG_BASE:   base_q   <= cfg_data;
				REG_LIMIT:  limit_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_eff = (LEN_W'(plen_q) > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
	                                                       : LEN_W'(plen_q);
	assign cell_cfg.pat  = {pat_hi_q, pat_lo_q};
	assign cell_cfg.wild = wild_q;
	assign cell_cfg.len  = len_eff;

	assign accept    = s_axis_tvalid & s_axis_tready;
	assign fill_next = (fill_q < FILL_W'(PATTERN_MAX)) ? fill_q + FILL_W'(1) : fill_q;

	assign chain[0] = s_axis_tdata[7:0];

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		if (i < PATTERN_MAX - 1) begin : g_mid
			wbps_cell #(.POS(i)) u_cell (
				.clk      (clk),
				.step     (accept),
				.byte_in  (chain[i]),
				.cfg      (cell_cfg),
				.byte_out (chain[i+1]),
				.hit      (hits[i])
			);
		end else begin : g_end
			wbps_cell #(.POS(i)) u_cell (
				.clk      (clk),
				.step     (accept),
				.byte_in  (chain[i]),
				.cfg      (cell_cfg),
				.byte_out (),
				.hit      (hits[i])
			);
		end
	end

	assign all_hit = &hits;
	assign hit     = (len_eff != '0) & (LEN_W'(fill_next) >= len_eff) & all_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			fill_q <= '0;
			v_s1_q <= 1'b0;
		end else begin
			if (accept) begin
				off_q  <= s_axis_tlast ? '0 : off_q + ADDR_W'(1);
				fill_q <= s_axis_tlast ? '0 : fill_next;
				v_s1_q <= 1'b1;
			end else if (s1_take) begin
				v_s1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.hit   <= hit;
			item_s1.last  <= s_axis_tlast;
			item_s1.start <= off_q - (ADDR_W'(len_eff) - ADDR_W'(1));
		end
	end

	assign s_axis_tready = !v_s1_q | s1_take;

	wbps_report u_report (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v_s1_q),
		.item          (item_s1),
		.take          (s1_take),
		.region_base   (base_q),
		.result_limit  (limit_q),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.match_address (match_address),
		.match_index   (match_index)
	);

	assign m_axis_tdata = {2'b00, match_index, match_address};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for wildcard_byte_pattern_scanner_core: byte stream in, match reports out.
// An internal scan predictor produces the expected matches; depends on wbps_pkg and the core.
module tb_top;
	import wbps_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int WIN_MAX     = 16;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  idx;
	} match_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;    // [7:0] data_byte
	logic                    s_axis_tlast;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;    // [63:0] match_address, [77:64] match_index
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// scan predictor: configuration copy
	logic [15:0][7:0]        pat_bytes;
	logic [15:0]             cfg_wild;
	logic [4:0]              scan_len;
	logic [ADDR_W-1:0]       cfg_base;
	logic [CNT_W-1:0]        cfg_limit;
	// scan predictor: state
	logic [7:0]              hist [0:WIN_MAX-2];
	logic [ADDR_W-1:0]       offset;
	logic [4:0]              fill;
	logic [CNT_W-1:0]        found;

	byte_item_t              byte_queue[$];
	match_t                  pending_matches[$];
	int                      items_queued = 0;
	int                      items_taken = 0;
	int                      fail_count = 0;
	int                      cycles = 0;
	int                      send_gap = 0;
	int                      rx_stall = 0;
	bit                      tx_idle = 1'b1;
	bit                      rx_idle = 1'b1;
	logic                    byte_taken = 1'b0;

	wildcard_byte_pattern_scanner_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap(input bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic scan_byte(input logic [7:0] cur, input logic last);
		int          n;
		int          back;
		logic        hit;
		logic [7:0]  b;
		match_t      mt;
		n = (scan_len > WIN_MAX) ? WIN_MAX : int'(scan_len);
		if (fill < WIN_MAX)
			fill++;
		if (n != 0 && fill >= n) begin
			hit = 1'b1;
			for (int k = 0; k < n; k++) begin
				back = n - 1 - k;
				b = (back == 0) ? cur : hist[back-1];
				if (!cfg_wild[k] && b != pat_bytes[k])
					hit = 1'b0;
			end
			if (hit && found < cfg_limit) begin
				mt.addr = cfg_base + offset - ADDR_W'(n - 1);
				mt.idx  = found;
				pending_matches.insert(pending_matches.size(), mt);
				found++;
			end
		end
		for (int k = WIN_MAX - 2; k > 0; k--)
			hist[k] = hist[k-1];
		hist[0] = cur;
		if (last) begin
			offset = '0;
			fill = '0;
			found = '0;
		end else begin
			offset++;
		end
	endtask

	// checks, then prediction for the byte transferred at this edge
	always @(posedge clk) begin
		match_t m;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_matches.size() == 0) begin
				$error("unexpected match: match_address %h match_index %0d",
					m_axis_tdata[63:0], m_axis_tdata[77:64]);
				fail_count++;
			end else begin
				m = pending_matches.pop_front();
				if (m_axis_tdata[63:0] !== m.addr) begin
					$error("match_address: expected %h, got %h", m.addr, m_axis_tdata[63:0]);
					fail_count++;
				end
				if (m_axis_tdata[77:64] !== m.idx) begin
					$error("match_index: expected %0d, got %0d", m.idx, m_axis_tdata[77:64]);
					fail_count++;
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			scan_byte(s_axis_tdata[7:0], s_axis_tlast);
			items_taken++;
		end
		byte_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	// byte driver
	always @(negedge clk) begin
		byte_item_t nxt;
		if (arst_n && (!s_axis_tvalid || byte_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (byte_queue.size() != 0) begin
				nxt = byte_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= nxt.data;
				s_axis_tlast  <= nxt.last;
				send_gap = pick_gap(tx_idle);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result sink backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_stall = pick_gap(rx_idle);
			end
		end
	end

	task automatic send_byte(input logic [7:0] data, input logic last);
		byte_item_t it;
		it.data = data;
		it.last = last;
		byte_queue.insert(byte_queue.size(), it);
		items_queued++;
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [63:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		case (r)
			REG_PAT_LO: pat_bytes[7:0] = v;
			REG_PAT_HI: pat_bytes[15:8] = v;
			REG_WILD:   cfg_wild = v[15:0];
			REG_LEN:    scan_len = v[4:0];
			REG_BASE:   cfg_base = v;
			REG_LIMIT:  cfg_limit = v[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
			input logic [15:0] wild, input logic [4:0] len,
			input logic [63:0] base, input logic [CNT_W-1:0] lim);
		write_reg(REG_PAT_LO, lo);
		write_reg(REG_PAT_HI, hi);
		write_reg(REG_WILD, 64'(wild));
		write_reg(REG_LEN, 64'(len));
		write_reg(REG_BASE, base);
		write_reg(REG_LIMIT, 64'(lim));
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || pending_matches.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly pattern instances with random wildcard content, some corrupted, plus noise
	task automatic queue_random(input int count);
		int         n;
		int         bad;
		int         made;
		logic [7:0] d;
		n = (scan_len > WIN_MAX) ? WIN_MAX : int'(scan_len);
		made = 0;
		while (made < count) begin
			if (n != 0 && $urandom_range(0, 99) < 60) begin
				bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
				for (int k = 0; k < n; k++) begin
					d = cfg_wild[k] ? 8'($urandom) : pat_bytes[k];
					if (k == bad)
						d = d ^ 8'(1 << $urandom_range(0, 7));
					send_byte(d, $urandom_range(0, 199) == 0);
					made++;
				end
			end else begin
				d = $urandom_range(0, 1) ? 8'($urandom) : pat_bytes[$urandom_range(0, 15)];
				send_byte(d, $urandom_range(0, 39) == 0);
				made++;
			end
		end
	endtask

	initial begin
		logic [63:0]      lo;
		logic [63:0]      hi;
		logic [15:0]      wild;
		logic [4:0]       len;
		logic [63:0]      base;
		logic [CNT_W-1:0] lim;
		logic [7:0]       fillb;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		pat_bytes     = '0;
		cfg_wild      = '0;
		scan_len      = '0;
		cfg_base      = '0;
		cfg_limit     = DEFAULT_LIMIT;
		offset        = '0;
		fill          = '0;
		found         = '0;
		for (int k = 0; k < WIN_MAX - 1; k++)
			hist[k] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: zero length, nothing reported
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b1);
		send_byte(8'h3C, 1'b0);
		wait_idle();

		// 3-byte pattern, middle byte wildcard, address wraps past all ones;
		// short history at region start, match on the last byte
		set_config(64'h0000_0000_0033_0011, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0002, 5'd3,
			64'hFFFF_FFFF_FFFF_FFFE, 14'd16383);
		send_byte(8'h11, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h99, 1'b0);
		send_byte(8'h33, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h33, 1'b1);
		wait_idle();

		// overlapping matches cut by a limit of two; region end clears count and fill
		set_config(64'h0000_0000_0000_AAAA, 64'h0, 16'h0000, 5'd2, 64'h1000, 14'd2);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b0);
		wait_idle();

		// limit of zero with an all-wildcard pattern
		set_config(64'h0, 64'h0, 16'hFFFF, 5'd1, 64'h0, 14'd0);
		send_byte(8'h7E, 1'b0);
		send_byte(8'h81, 1'b1);
		wait_idle();

		for (int p = 0; p < 12; p++) begin
			tx_idle = (p % 4 != 1) && ($urandom_range(0, 3) != 0);
			rx_idle = (p % 4 != 1) && ($urandom_range(0, 3) != 0);
			if (p == 0) begin
				lo = '1; hi = '1; wild = 16'hFFFF; len = 5'd31; base = '1; lim = 14'd16383;
			end else if (p == 1) begin
				lo = '0; hi = '0; wild = 16'h0000; len = 5'd16; base = '0; lim = 14'd1;
			end else begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
				if ($urandom_range(0, 3) == 0) begin
					fillb = 8'($urandom);
					lo = {8{fillb}};
					hi = {8{fillb}};
				end
				case ($urandom_range(0, 3))
					0: wild = 16'h0000;
					1: wild = 16'hFFFF;
					default: wild = 16'($urandom) & 16'($urandom);
				endcase
				case ($urandom_range(0, 9))
					0: len = 5'd0;
					1: len = 5'd1;
					2: len = 5'd16;
					3: len = 5'($urandom_range(17, 31));
					default: len = 5'($urandom_range(2, 15));
				endcase
				case ($urandom_range(0, 3))
					0: base = '0;
					1: base = '1 - 64'($urandom_range(0, 40));
					default: base = {$urandom, $urandom};
				endcase
				case ($urandom_range(0, 5))
					0: lim = 14'd0;
					1: lim = 14'($urandom_range(1, 4));
					2: lim = 14'd16383;
					3: lim = DEFAULT_LIMIT;
					default: lim = 14'($urandom_range(5, 16383));
				endcase
			end
			set_config(lo, hi, wild, len, base, lim);
			queue_random(110);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
